// ===== rtl/core/ucd_pkg.sv =====
// Shared types and constants for the seconds-to-calendar-date unit.
// No dependencies; imported by every module under rtl/core.
package ucd_pkg;

  // Divider operand and quotient width
  localparam int DivW     = 32;
  localparam int RemW     = 6;

  // Quotient widths of the three splits: t/60, t/3600, t/86400
  localparam int MinCntW  = 27;
  localparam int HourCntW = 21;
  localparam int DayCntW  = 16;

  // Day count rebased to the Common Era fits 20 bits
  localparam int DayW     = 20;
  localparam int DoyW     = 9;
  localparam int YearW    = 12;
  localparam int MonW     = 4;

  localparam logic [DayW-1:0] CeDayOffset = 20'd719499;

  // Reciprocal division t/d = (t * Recip) >> Shift, exact for any 32-bit t
  localparam logic [DivW-1:0] RecipDiv60 = 32'h8888_8889;
  localparam logic [DivW-1:0] RecipDiv24 = 32'hAAAA_AAAB;
  localparam int              ShiftDiv60 = 37;
  localparam int              ShiftDiv24 = 36;
  localparam logic [RemW-1:0] Div60      = 6'd60;
  localparam logic [RemW-1:0] Div24      = 6'd24;

  // Command to the shared divider
  typedef struct packed {
    logic             start;
    logic             by24;   // divisor 24 when set, else 60
  } div_cmd_t;

  // Status back from the shared divider
  typedef struct packed {
    logic            done;
    logic [RemW-1:0] rem;
  } div_stat_t;

endpackage

// ===== rtl/core/unix_seconds_to_calendar_date_unit.sv =====
// Top level: sequencer over the shared divider and the date search.
// Depends on ucd_pkg, ucd_divider, ucd_search.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  request  | start, busy          | seconds_since_epoch[31:0]
//  result   | done (1-cycle pulse) | second, minute, hour, day_of_month, month, year
//
// A request is taken when start is high and busy is low; busy stays high through
// the result cycle. Three divider passes (60, 60, 24) run first; then the search
// steps through each March-based year after 1969 (0 to 136) and each month after
// March (0 to 11), and done follows. The next request is taken only once busy
// falls again after the result. Results show for one cycle on done; the receiver
// cannot stall. Sync reset.
module unix_seconds_to_calendar_date_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [31:0]               seconds_since_epoch,
  output logic                      done,
  output logic [5:0]                second,
  output logic [5:0]                minute,
  output logic [4:0]                hour,
  output logic [4:0]                day_of_month,
  output logic [ucd_pkg::MonW-1:0]  month,
  output logic [ucd_pkg::YearW-1:0] year
);
  import ucd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEC  = 3'd1;
  localparam logic [2:0] ST_MIN  = 3'd2;
  localparam logic [2:0] ST_HR   = 3'd3;
  localparam logic [2:0] ST_SRCH = 3'd4;

  logic [2:0]      state;
  logic [5:0]      sec_r;
  logic [5:0]      min_r;
  logic [4:0]      hr_r;

  div_cmd_t        div_cmd;
  div_stat_t       div_stat;
  logic [DivW-1:0] div_operand;
  logic [DivW-1:0] div_q;
  logic            srch_start;
  logic [DayW-1:0] srch_days;
  logic            srch_done;

  assign busy = (state != ST_IDLE);

  // next divider command, operands zero-extended from their quotient width
  always_comb begin
    div_cmd     = '0;
    div_operand = '0;
    srch_start  = 1'b0;
    srch_days   = {{(DayW-DayCntW){1'b0}}, div_q[DayCntW-1:0]} + CeDayOffset;
    case (state)
      ST_IDLE: begin
        div_cmd.start = start;
        div_operand   = seconds_since_epoch;
      end
      ST_SEC: begin
        div_cmd.start = div_stat.done;
        div_operand   = {{(DivW-MinCntW){1'b0}}, div_q[MinCntW-1:0]};
      end
      ST_MIN: begin
        div_cmd.start = div_stat.done;
        div_cmd.by24  = 1'b1;
        div_operand   = {{(DivW-HourCntW){1'b0}}, div_q[HourCntW-1:0]};
      end
      ST_HR: begin
        srch_start = div_stat.done;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (start) state <= ST_SEC;
        ST_SEC: begin
          if (div_stat.done) begin
            sec_r <= div_stat.rem;
            state <= ST_MIN;
          end
        end
        ST_MIN: begin
          if (div_stat.done) begin
            min_r <= div_stat.rem;
            state <= ST_HR;
          end
        end
        ST_HR: begin
          if (div_stat.done) begin
            hr_r  <= div_stat.rem[4:0];
            state <= ST_SRCH;
          end
        end
        ST_SRCH: if (srch_done) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  ucd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .operand  (div_operand),
    .stat     (div_stat),
    .quotient (div_q)
  );

  ucd_search u_srch (
    .clk          (clk),
    .rst          (rst),
    .start        (srch_start),
    .days         (srch_days),
    .done         (srch_done),
    .day_of_month (day_of_month),
    .month        (month),
    .year         (year)
  );

  assign done   = srch_done;
  assign second = sec_r;
  assign minute = min_r;
  assign hour   = hr_r;

endmodule

// ===== rtl/core/ucd_divider.sv =====
// Shared divider by 60 or 24: reciprocal multiply, then quotient and remainder.
// Depends on ucd_pkg (div_cmd_t, div_stat_t, reciprocal constants, widths).
module ucd_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  ucd_pkg::div_cmd_t        cmd,
  input  logic [ucd_pkg::DivW-1:0] operand,
  output ucd_pkg::div_stat_t       stat,
  output logic [ucd_pkg::DivW-1:0] quotient
);
  import ucd_pkg::*;

  logic [2*DivW-1:0] prod;
  logic [DivW-1:0]   opnd;
  logic [DivW-1:0]   q;
  logic [RemW-1:0]   rem;
  logic              active;
  logic              done;
  logic              by24;

  logic [DivW-1:0]   magic;
  logic [DivW-1:0]   q_next;
  logic [RemW-1:0]   dvsr;
  logic [RemW-1:0]   rem_next;

  // reciprocal for the requested divisor
  always_comb begin
    magic = cmd.by24 ? RecipDiv24 : RecipDiv60;
  end

  // quotient from the high product bits; remainder fits in the low bits
  always_comb begin
    if (by24) begin
      q_next = DivW'(prod >> ShiftDiv24);
      dvsr   = Div24;
    end else begin
      q_next = DivW'(prod >> ShiftDiv60);
      dvsr   = Div60;
    end
    rem_next = opnd[RemW-1:0] - q_next[RemW-1:0] * dvsr;
  end

  // multiply into prod on start; from prod, register quotient, remainder and done
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        prod   <= {{DivW{1'b0}}, operand} * {{DivW{1'b0}}, magic};
        opnd   <= operand;
        by24   <= cmd.by24;
        active <= 1'b1;
      end else if (active) begin
        q      <= q_next;
        rem    <= rem_next;
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  assign stat.done = done;
  assign stat.rem  = rem;
  assign quotient  = q;

endmodule

// ===== rtl/core/ucd_search.sv =====
// Year and month stepping search over a shared magnitude compare.
// Depends on ucd_pkg (widths). Days are counted from the Common Era.
module ucd_search (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ucd_pkg::DayW-1:0]  days,
  output logic                      done,
  output logic [4:0]                day_of_month,
  output logic [ucd_pkg::MonW-1:0]  month,
  output logic [ucd_pkg::YearW-1:0] year
);
  import ucd_pkg::*;

  localparam logic [1:0] SS_IDLE  = 2'd0;
  localparam logic [1:0] SS_YEAR  = 2'd1;
  localparam logic [1:0] SS_MONTH = 2'd2;

  // days before month m, March-based: 367*m/12
  function automatic logic [DoyW-1:0] days_before_month(input logic [MonW-1:0] m);
    logic [DoyW-1:0] r;
    case (m)
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  logic [1:0]       state;
  logic [DayW-1:0]  tval;
  logic [YearW-1:0] yr;
  logic [DayW-1:0]  cur;   // days before yr
  logic [DayW-1:0]  nxt;   // days before yr+1
  logic [1:0]       c4;    // (yr+1) mod 4
  logic [6:0]       c100;  // (yr+1) mod 100
  logic [8:0]       c400;  // (yr+1) mod 400
  logic [DoyW-1:0]  doy;
  logic [MonW-1:0]  mon;

  logic [1:0]       c4_next;
  logic [6:0]       c100_next;
  logic [8:0]       c400_next;
  logic             leap;
  logic [DayW-1:0]  cmp_a;
  logic [DayW-1:0]  cmp_b;
  logic             gt;
  logic [DayW-1:0]  yr_diff;
  logic [DoyW-1:0]  dom_diff;
  logic [MonW-1:0]  mon_adj;

  // year length of the next year from the mod counters
  always_comb begin
    c4_next   = c4 + 2'd1;
    c100_next = (c100 == 7'd99)  ? 7'd0 : c100 + 7'd1;
    c400_next = (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
    leap      = ((c4_next == 2'd0) && (c100_next != 7'd0)) || (c400_next == 9'd0);
  end

  // shared compare: year threshold or month boundary
  always_comb begin
    if (state == SS_YEAR) begin
      cmp_a = tval;
      cmp_b = nxt + 20'd30;
    end else begin
      cmp_a = {{(DayW-DoyW){1'b0}}, doy};
      cmp_b = {{(DayW-DoyW){1'b0}}, days_before_month(mon + 4'd1)};
    end
    gt       = (cmp_a > cmp_b);
    yr_diff  = tval - cur;
    dom_diff = doy - days_before_month(mon);
    mon_adj  = mon + 4'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SS_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        SS_IDLE: begin
          if (start) begin
            tval  <= days;
            yr    <= 12'd1969;
            cur   <= 20'd719162;
            nxt   <= 20'd719527;
            c4    <= 2'd2;
            c100  <= 7'd70;
            c400  <= 9'd370;
            state <= SS_YEAR;
          end
        end
        SS_YEAR: begin
          if (gt && (yr != 12'd4095)) begin
            yr   <= yr + 12'd1;
            cur  <= nxt;
            nxt  <= nxt + (leap ? 20'd366 : 20'd365);
            c4   <= c4_next;
            c100 <= c100_next;
            c400 <= c400_next;
          end else begin
            doy   <= yr_diff[DoyW-1:0];
            mon   <= 4'd1;
            state <= SS_MONTH;
          end
        end
        SS_MONTH: begin
          if (gt && (mon != 4'd12)) begin
            mon <= mon + 4'd1;
          end else begin
            day_of_month <= dom_diff[4:0];
            // shift March-based month to January-based
            if (mon_adj > 4'd12) begin
              month <= mon_adj - 4'd12;
              year  <= yr + 12'd1;
            end else begin
              month <= mon_adj;
              year  <= yr;
            end
            done  <= 1'b1;
            state <= SS_IDLE;
          end
        end
        default: state <= SS_IDLE;
      endcase
    end
  end

endmodule
